[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the SHA-256 checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned LEN_POS      = 56;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned SCHED_WORDS  = 16;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    case (idx)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      3'd7: init_hash = 32'h5be0cd19;
      default: init_hash = 32'h6a09e667;
    endcase
  endfunction

  function automatic word_t round_const(input logic [5:0] idx);
    case (idx)
      6'd0:  round_const = 32'h428a2f98;
      6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;
      6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;
      6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;
      6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;
      6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;
      6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;
      6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;
      6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;
      6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;
      6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;
      6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;
      6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;
      6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;
      6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;
      6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;
      6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;
      6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;
      6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;
      6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;
      6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;
      6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;
      6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;
      6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;
      6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;
      6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;
      6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;
      6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;
      6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;
      6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;
      6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;
      6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;
      6'd63: round_const = 32'hc67178f2;
      default: round_const = 32'h428a2f98;
    endcase
  endfunction

endpackage

`default_nettype wire

[src/sha256_stream_hasher.sv]
// A byte that leaves the block short is stored and input stays open; the 64th byte of
//   a block starts the rounds and chain add, and no input is taken until they end.
// End of message: pad step, padded block(s) hashed (one or two), then 8 digest words.
// No byte is taken while a block is hashed or while the digest is output.
// Reset: rst_n low (synchronous) reloads the initial hash, clears byte and bit counts;
//   the block buffer is not cleared.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream: one shared round unit under a small sequencer,
// with a 16-word sliding message schedule window.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] message_byte
  input  wire logic [0:0]  in_tuser,   // [0] byte_valid
  input  wire logic        in_tlast,   // message_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic             out_tlast   // digest_last
);

  localparam int unsigned SW = sha256_pkg::SCHED_WORDS;
  localparam int unsigned DW = sha256_pkg::DIGEST_WORDS;

  sha256_pkg::state_t state_r, state_nxt;

  sha256_pkg::word_t w_r     [SW];
  sha256_pkg::word_t w_nxt   [SW];
  sha256_pkg::word_t v_r     [DW];
  sha256_pkg::word_t v_nxt   [DW];
  sha256_pkg::word_t chain_r [DW];
  sha256_pkg::word_t chain_nxt [DW];

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  ocnt_r, ocnt_nxt;
  logic        endp_r, endp_nxt;    // end seen with the byte that filled a block
  logic        fin_r, fin_nxt;      // block in flight is the last one
  logic        extra_r, extra_nxt;  // a length-only block still follows

  logic              in_acc;
  logic              out_acc;
  logic [1:0]        lane;
  sha256_pkg::word_t t1, t2, w_new;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign lane    = ~fill_r[1:0];

  // round unit
  always_comb begin
    t1 = v_r[7] + sha256_pkg::big_sigma1(v_r[4]) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
         sha256_pkg::round_const(rnd_r) + w_r[0];
    t2 = sha256_pkg::big_sigma0(v_r[0]) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = sha256_pkg::small_sigma1(w_r[14]) + w_r[9] +
            sha256_pkg::small_sigma0(w_r[1]) + w_r[0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] && (&fill_r)) begin
            state_nxt = sha256_pkg::ST_ROUND;
          end else if (in_tlast) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        state_nxt = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (&rnd_r) begin
          state_nxt = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        if (endp_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else if (fin_r) begin
          state_nxt = sha256_pkg::ST_OUT;
        end else if (extra_r) begin
          state_nxt = sha256_pkg::ST_ROUND;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_acc && (ocnt_r == 3'(DW - 1))) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == sha256_pkg::ST_IDLE);
    out_tvalid = (state_r == sha256_pkg::ST_OUT);
    out_tdata  = chain_r[0];
    out_tlast  = (ocnt_r == 3'(DW - 1));
  end

  // datapath
  always_comb begin
    w_nxt     = w_r;
    v_nxt     = v_r;
    chain_nxt = chain_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    rnd_nxt   = rnd_r;
    ocnt_nxt  = ocnt_r;
    endp_nxt  = endp_r;
    fin_nxt   = fin_r;
    extra_nxt = extra_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        v_nxt   = chain_r;
        rnd_nxt = '0;
        if (in_acc) begin
          if (in_tuser[0]) begin
            w_nxt[fill_r[5:2]][{lane, 3'b000} +: 8] = in_tdata[7:0];
            fill_nxt = fill_r + 6'd1;  // wraps to zero on a full block
            bits_nxt = bits_r + 64'd8;
          end
          endp_nxt = in_tlast;
        end
      end
      sha256_pkg::ST_PAD: begin
        v_nxt    = chain_r;
        rnd_nxt  = '0;
        endp_nxt = 1'b0;
        for (int j = 0; j < SW; j++) begin
          for (int b = 0; b < 4; b++) begin
            if (6'(4 * j + b) == fill_r) begin
              w_nxt[j][8 * (3 - b) +: 8] = sha256_pkg::PAD_BYTE;
            end else if (6'(4 * j + b) > fill_r) begin
              w_nxt[j][8 * (3 - b) +: 8] = 8'h00;
            end
          end
        end
        if (fill_r < 6'(sha256_pkg::LEN_POS)) begin
          w_nxt[SW - 2] = bits_r[63:32];
          w_nxt[SW - 1] = bits_r[31:0];
          fin_nxt       = 1'b1;
          extra_nxt     = 1'b0;
        end else begin
          fin_nxt   = 1'b0;
          extra_nxt = 1'b1;
        end
      end
      sha256_pkg::ST_ROUND: begin
        for (int j = 0; j < SW - 1; j++) begin
          w_nxt[j] = w_r[j + 1];
        end
        w_nxt[SW - 1] = w_new;
        v_nxt[0] = t1 + t2;
        v_nxt[1] = v_r[0];
        v_nxt[2] = v_r[1];
        v_nxt[3] = v_r[2];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[5] = v_r[4];
        v_nxt[6] = v_r[5];
        v_nxt[7] = v_r[6];
        rnd_nxt  = rnd_r + 6'd1;
      end
      sha256_pkg::ST_ADD: begin
        for (int i = 0; i < DW; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        v_nxt   = chain_nxt;
        rnd_nxt = '0;
        if (!endp_r && fin_r) begin
          fill_nxt = '0;
          bits_nxt = '0;
          ocnt_nxt = '0;
        end else if (!endp_r && extra_r) begin
          // length-only block after a pad that spilled past byte 55
          for (int j = 0; j < SW - 2; j++) begin
            w_nxt[j] = '0;
          end
          w_nxt[SW - 2] = bits_r[63:32];
          w_nxt[SW - 1] = bits_r[31:0];
          extra_nxt     = 1'b0;
          fin_nxt       = 1'b1;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_acc) begin
          for (int i = 0; i < DW - 1; i++) begin
            chain_nxt[i] = chain_r[i + 1];
          end
          chain_nxt[DW - 1] = '0;
          ocnt_nxt = ocnt_r + 3'd1;
          if (ocnt_r == 3'(DW - 1)) begin
            for (int i = 0; i < DW; i++) begin
              chain_nxt[i] = sha256_pkg::init_hash(3'(i));
            end
            fin_nxt = 1'b0;
          end
        end
      end
      default: begin
        rnd_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      ocnt_r  <= '0;
      endp_r  <= 1'b0;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
      for (int i = 0; i < DW; i++) begin
        chain_r[i] <= sha256_pkg::init_hash(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      rnd_r   <= rnd_nxt;
      ocnt_r  <= ocnt_nxt;
      endp_r  <= endp_nxt;
      fin_r   <= fin_nxt;
      extra_r <= extra_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

endmodule

`default_nettype wire

[src/sha256_checker.sv]
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sha256_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,   // message_end
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,  // [31:0] digest_word
  input wire logic        out_tlast   // digest_last
);

  logic out_stall;
  logic out_done;
  logic in_end;

  assign out_stall = out_tvalid && !out_tready;
  assign out_done  = out_tvalid && out_tready && out_tlast;
  assign in_end    = in_tvalid && in_tready && in_tlast;

  // a stalled digest word holds
  `ASSERT_CLK(a_out_hold, out_stall |=> out_tvalid && $stable({out_tdata, out_tlast}), "moved")

  // input is closed while the digest is shown
  `ASSERT_CLK(a_no_overlap, !(in_tready && out_tvalid), "input open during digest output")

  // after the last digest word the hasher is ready for a new message
  `ASSERT_CLK(a_ready_after_last, out_done |=> in_tready && !out_tvalid, "not idle after digest")

  // an item that ends the message always starts work
  `ASSERT_CLK(a_end_busy, in_end |=> !in_tready, "end item did not start finalization")

  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid && in_tready, "busy after reset")

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
